// ===== src/puat_pkg.sv =====
// Shared types and codes for the per-ID usage accounting table.
package puat_pkg;

  localparam logic [1:0] KindCharge   = 2'd0;
  localparam logic [1:0] KindRelease  = 2'd1;
  localparam logic [1:0] KindRegister = 2'd2;

  localparam logic [1:0] StExisting = 2'd0;
  localparam logic [1:0] StNew      = 2'd1;
  localparam logic [1:0] StUnknown  = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam int unsigned IdW    = 32;
  localparam int unsigned AmtW   = 32;
  localparam int unsigned SlotOW = 3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdW-1:0]  requester_id;
    logic [AmtW-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SlotOW-1:0] slot;
    logic [AmtW-1:0]   usage;
    logic [AmtW-1:0]   peak_usage;
  } rsp_t;

endpackage

// ===== src/per_id_usage_accounting_table.sv =====
// Top level of the per-ID usage accounting table.
//
//   channel | valid       | ready       | payload
//   request | req_valid_i | req_ready_o | req_i  (puat_pkg::req_t)
//   result  | rsp_valid_o | rsp_ready_i | rsp_o  (puat_pkg::rsp_t)
//
// One request per cycle unless stalled; each result is registered from in_q.
// The table is read and updated in one pass from the input register.
// Reset empties the table (occupancy count to zero) and drops both stages.
// A held result stalls the input register, which then stalls the request side.
module per_id_usage_accounting_table #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  puat_pkg::req_t   req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output puat_pkg::rsp_t   rsp_o
);

  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned AmtW  = puat_pkg::AmtW;

  logic                                     in_vld_q;
  puat_pkg::req_t                           in_q;
  logic                                     out_vld_q;
  puat_pkg::rsp_t                           out_q;
  logic [TABLE_SLOTS-1:0][puat_pkg::IdW-1:0] ids_q;
  logic [TABLE_SLOTS-1:0][AmtW-1:0]         usage_q;
  logic [TABLE_SLOTS-1:0][AmtW-1:0]         peak_q;
  logic [CntW-1:0]                          count_q;
  logic [CntW-1:0]                          count_d;

  logic             advance;
  logic             hit;
  logic [SlotW-1:0] hit_idx;
  logic             is_charge;
  logic             is_release;
  logic             wants_slot;
  logic             full;
  logic             alloc;
  logic             found;
  logic [SlotW-1:0] wr_idx;
  logic [AmtW-1:0]  base_usage;
  logic [AmtW-1:0]  base_peak;
  logic [AmtW:0]    sum;
  logic [AmtW-1:0]  new_usage;
  logic [AmtW-1:0]  new_peak;
  logic [31:0]      slot_wide;
  puat_pkg::rsp_t   out_d;

  assign advance     = in_vld_q && (!out_vld_q || rsp_ready_i);
  assign req_ready_o = !in_vld_q || advance;
  assign rsp_valid_o = out_vld_q;
  assign rsp_o       = out_q;

  puat_lookup #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_lookup (
    .ids_i  (ids_q),
    .count_i(count_q),
    .id_i   (in_q.requester_id),
    .hit_o  (hit),
    .idx_o  (hit_idx)
  );

  always_comb begin
    is_charge  = (in_q.kind == puat_pkg::KindCharge);
    is_release = (in_q.kind == puat_pkg::KindRelease);
    wants_slot = is_charge || (in_q.kind == puat_pkg::KindRegister);
    full       = (count_q >= CntW'(TABLE_SLOTS));
    alloc      = !hit && wants_slot && !full;
    found      = hit || alloc;
    wr_idx     = hit ? hit_idx : count_q[SlotW-1:0];
    base_usage = hit ? usage_q[hit_idx] : '0;
    base_peak  = hit ? peak_q[hit_idx] : '0;
    sum        = {1'b0, base_usage} + {1'b0, in_q.amount};
    new_usage  = base_usage;
    new_peak   = base_peak;
    if (is_charge) begin
      new_usage = sum[AmtW] ? '1 : sum[AmtW-1:0];
      if (new_usage > base_peak) begin
        new_peak = new_usage;
      end
    end else if (is_release) begin
      new_usage = (in_q.amount > base_usage) ? '0 : base_usage - in_q.amount;
    end
    count_d   = (advance && alloc) ? count_q + CntW'(1) : count_q;
    slot_wide = 32'(wr_idx);
    if (found) begin
      out_d.status     = hit ? puat_pkg::StExisting : puat_pkg::StNew;
      out_d.slot       = slot_wide[puat_pkg::SlotOW-1:0];
      out_d.usage      = new_usage;
      out_d.peak_usage = new_peak;
    end else begin
      out_d.status     = wants_slot ? puat_pkg::StFull : puat_pkg::StUnknown;
      out_d.slot       = '0;
      out_d.usage      = '0;
      out_d.peak_usage = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      count_q <= count_d;
      if (req_ready_o) begin
        in_vld_q <= req_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      in_q <= req_i;
    end
    if (advance) begin
      out_q <= out_d;
      if (found) begin
        ids_q[wr_idx]   <= in_q.requester_id;
        usage_q[wr_idx] <= new_usage;
        peak_q[wr_idx]  <= new_peak;
      end
    end
  end

endmodule

// ===== src/puat_lookup.sv =====
// Parallel ID match over the occupied slots, lowest slot wins.
module puat_lookup #(
  parameter int unsigned TABLE_SLOTS = 8,
  localparam int unsigned SlotW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1)
) (
  input  logic [TABLE_SLOTS-1:0][puat_pkg::IdW-1:0] ids_i,
  input  logic [CntW-1:0]                           count_i,
  input  logic [puat_pkg::IdW-1:0]                  id_i,
  output logic                                      hit_o,
  output logic [SlotW-1:0]                          idx_o
);

  logic [TABLE_SLOTS-1:0] match;

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      match[i] = (CntW'(i) < count_i) && (ids_i[i] == id_i);
    end
  end

  always_comb begin
    hit_o = 1'b0;
    idx_o = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_o = 1'b1;
        idx_o = SlotW'(i);
      end
    end
  end

endmodule
